>>> design/itoa_pkg.sv
// itoa_pkg: shared types and constants of the integer to ASCII converter.
// Used by itoa_ctrl, itoa_dp and integer_to_ascii_radix; no dependencies.
`default_nettype none

package itoa_pkg;

    localparam int RADIX_W    = 5;
    localparam int REM_W      = 4;
    localparam int CHAR_W     = 7;
    localparam int O_TDATA_W  = 8;
    localparam int DIV_BITS   = 8;   // quotient bits resolved per divider cycle

    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;
    localparam logic [RADIX_W-1:0] RADIX_DEC = 5'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

    typedef enum logic [1:0] {
        OUT_SIGN  = 2'd0,
        OUT_DIGIT = 2'd1,
        OUT_BAD   = 2'd2
    } t_out_sel;

    typedef struct packed {
        logic     load;
        logic     div_step;
        logic     div_first;
        logic     dig_wr;
        logic     rd_en;
        logic     out_load;
        t_out_sel out_sel;
        logic     out_last;
    } t_cmd;

    typedef struct packed {
        logic bad_in;
        logic neg_dec_in;
        logic quot_zero;
        logic out_free;
    } t_sts;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [REM_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else begin
            c = CHAR_A + CHAR_W'(d - 4'd10);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> design/integer_to_ascii_radix.sv
// integer_to_ascii_radix: top level, converts a signed integer to ASCII
// digits in base 2..16. Depends on itoa_pkg, itoa_ctrl and itoa_dp.
//
// Usage:
//   Slave channel: one transaction carries value and radix. Master channel:
//   one transaction per character, most significant digit first, tlast on
//   the final character. A '-' leads only for negative values in base 10.
//   A radix outside 2..16 yields one character of zero with tuser and tlast.
// Sequencing:
//   Each digit takes STEPS = ceil(VALUE_BITS/8) steps of the radix divider,
//   which resolves 8 quotient bits a cycle, then a check for a zero quotient.
//   Each character then takes a digit memory read and an output register load.
//   A new item is taken only once the previous item's last character is in
//   the output register.
// Reset: synchronous, active low; returns to idle with the output empty.
// Stall: a held tready freezes emission; the output register holds its
//   character and tlast/tuser until taken.
`default_nettype none

module integer_to_ascii_radix #(
    parameter int VALUE_BITS = 32
) (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    input  wire                                      i_s_tvalid,
    output logic                                     o_s_tready,
    // value, radix
    input  wire  [((VALUE_BITS+itoa_pkg::RADIX_W+7)/8)*8-1:0] i_s_tdata,
    output logic                                     o_m_tvalid,
    input  wire                                      i_m_tready,
    // ascii_char
    output logic [itoa_pkg::O_TDATA_W-1:0]           o_m_tdata,
    output logic                                     o_m_tlast,  // last_char
    output logic                                     o_m_tuser   // bad_radix
);
    import itoa_pkg::*;

    localparam int AW = $clog2(VALUE_BITS);

    t_cmd                  cmd;
    t_sts                  sts;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         rd_addr;
    logic [VALUE_BITS-1:0] value;
    logic [RADIX_W-1:0]    radix;

    assign value = i_s_tdata[VALUE_BITS-1:0];
    assign radix = i_s_tdata[VALUE_BITS+RADIX_W-1:VALUE_BITS];

    itoa_ctrl #(
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_wr_addr  (wr_addr),
        .o_rd_addr  (rd_addr)
    );

    itoa_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_value    (value),
        .i_radix    (radix),
        .i_cmd      (cmd),
        .i_wr_addr  (wr_addr),
        .i_rd_addr  (rd_addr),
        .o_sts      (sts),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

`default_nettype wire

>>> design/itoa_dp.sv
// itoa_dp: datapath - magnitude/quotient register, radix divider,
// digit memory and output register. Depends on itoa_pkg.
`default_nettype none

module itoa_dp #(
    parameter int VALUE_BITS = 32
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire  [VALUE_BITS-1:0]            i_value,
    input  wire  [itoa_pkg::RADIX_W-1:0]     i_radix,
    input  wire  itoa_pkg::t_cmd             i_cmd,
    input  wire  [$clog2(VALUE_BITS)-1:0]    i_wr_addr,
    input  wire  [$clog2(VALUE_BITS)-1:0]    i_rd_addr,
    output itoa_pkg::t_sts                   o_sts,
    output logic                             o_m_tvalid,
    input  wire                              i_m_tready,
    output logic [itoa_pkg::O_TDATA_W-1:0]   o_m_tdata,   // ascii_char
    output logic                             o_m_tlast,   // last_char
    output logic                             o_m_tuser    // bad_radix
);
    import itoa_pkg::*;

    localparam int STEPS = (VALUE_BITS + DIV_BITS - 1) / DIV_BITS;
    localparam int WBITS = STEPS * DIV_BITS;

    logic [WBITS-1:0]      r_quot, n_quot;
    logic [REM_W-1:0]      r_rem, n_rem;
    logic [RADIX_W-1:0]    r_base;
    logic [REM_W-1:0]      r_mem [VALUE_BITS];
    logic [REM_W-1:0]      r_rd_data;
    logic [CHAR_W-1:0]     r_char, n_char;
    logic [VALUE_BITS-1:0] mag;
    logic [RADIX_W-1:0]    t;

    assign mag = i_value[VALUE_BITS-1] ? (~i_value + 1'b1) : i_value;

    // restoring division, DIV_BITS quotient bits per cycle
    always_comb begin
        n_rem  = i_cmd.div_first ? '0 : r_rem;
        n_quot = r_quot;
        t      = '0;
        for (int j = 0; j < DIV_BITS; j++) begin
            t      = {n_rem, n_quot[WBITS-1]};
            n_quot = {n_quot[WBITS-2:0], 1'b0};
            if (t >= r_base) begin
                n_rem     = REM_W'(t - r_base);
                n_quot[0] = 1'b1;
            end else begin
                n_rem = t[REM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quot <= WBITS'(mag);
            r_base <= i_radix;
        end else if (i_cmd.div_step) begin
            r_quot <= n_quot;
            r_rem  <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.dig_wr) begin
            r_mem[i_wr_addr] <= n_rem;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_comb begin
        case (i_cmd.out_sel)
            OUT_SIGN:  n_char = CHAR_MINUS;
            OUT_DIGIT: n_char = digit_char(r_rd_data);
            default:   n_char = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_tvalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            o_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_char    <= n_char;
            o_m_tlast <= i_cmd.out_last;
            o_m_tuser <= (i_cmd.out_sel == OUT_BAD);
        end
    end

    assign o_m_tdata = {1'b0, r_char};

    assign o_sts.bad_in     = (i_radix < RADIX_MIN) || (i_radix > RADIX_MAX);
    assign o_sts.neg_dec_in = i_value[VALUE_BITS-1] && (i_radix == RADIX_DEC);
    assign o_sts.quot_zero  = (r_quot == '0);
    assign o_sts.out_free   = !o_m_tvalid || i_m_tready;

endmodule

`default_nettype wire

>>> design/itoa_ctrl.sv
// itoa_ctrl: controller FSM - divider sequencing, digit count, sign and
// bad-radix responses and most-significant-first emission. Depends on itoa_pkg.
`default_nettype none

module itoa_ctrl #(
    parameter int VALUE_BITS = 32
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_s_tvalid,
    output logic                             o_s_tready,
    input  wire  itoa_pkg::t_sts             i_sts,
    output itoa_pkg::t_cmd                   o_cmd,
    output logic [$clog2(VALUE_BITS)-1:0]    o_wr_addr,
    output logic [$clog2(VALUE_BITS)-1:0]    o_rd_addr
);
    import itoa_pkg::*;

    localparam int STEPS  = (VALUE_BITS + DIV_BITS - 1) / DIV_BITS;
    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int AW     = $clog2(VALUE_BITS);
    localparam int CNT_W  = $clog2(VALUE_BITS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_SIGN = 3'd3;
    localparam logic [2:0] S_RD   = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;
    localparam logic [2:0] S_BAD  = 3'd6;

    logic [2:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [AW-1:0]     r_idx, n_idx;
    logic              r_neg, n_neg;
    logic [CNT_W-1:0]  cnt_m1;
    logic              accept;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign cnt_m1     = r_cnt - 1'b1;
    assign o_wr_addr  = r_cnt[AW-1:0];
    assign o_rd_addr  = r_idx;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_neg   = r_neg;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_sts.bad_in) begin
                        n_state = S_BAD;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_neg      = i_sts.neg_dec_in;
                        n_cnt      = '0;
                        n_step     = '0;
                        n_state    = S_DIV;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step  = 1'b1;
                o_cmd.div_first = (r_step == '0);
                if (r_step == STEP_W'(STEPS - 1)) begin
                    o_cmd.dig_wr = 1'b1;
                    n_cnt        = r_cnt + 1'b1;
                    n_step       = '0;
                    n_state      = S_CHK;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_CHK: begin
                if (i_sts.quot_zero) begin
                    n_idx   = cnt_m1[AW-1:0];
                    n_state = r_neg ? S_SIGN : S_RD;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_SIGN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OUT_SIGN;
                    n_state        = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                o_cmd.out_sel = OUT_DIGIT;
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = (r_idx == '0);
                    if (r_idx == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx - 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            S_BAD: begin
                o_cmd.out_sel = OUT_BAD;
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_cnt   <= '0;
            r_neg   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_cnt   <= n_cnt;
            r_neg   <= n_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
    end

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("output register overwritten while occupied");

    a_cnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt < CNT_W'(VALUE_BITS)))
        else $error("digit count overflow");

    a_bad_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_sts.bad_in) |=> (r_state == S_BAD))
        else $error("bad radix not routed to error response");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.out_load && o_cmd.out_last) |=> (r_state == S_IDLE))
        else $error("conversion continued after last character");

endmodule

`default_nettype wire
